@@ rtl/core/wera_pkg.sv @@
// Package: widths, register indexes and constants of the wheel encoder accumulator.
package wera_pkg;

  localparam int COUNT_W = 15;
  localparam int RPT_W = 20;
  localparam int DB_W = 14;
  localparam int TOTAL_W = 40;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RPT_W;

  localparam int COUNT_MODULUS = 32767;
  localparam int COUNT_HALF = COUNT_MODULUS / 2;

  // signed difference of two counts plus room for the rollover correction
  localparam int DELTA_W = COUNT_W + 2;
  // signed delta times unsigned factor, plus one bit for the factor's zero-extended sign
  localparam int PROD_W = DELTA_W + RPT_W + 1;

  localparam logic [RPT_W-1:0] RPT_RESET = RPT_W'(279617);
  localparam logic [DB_W-1:0] DB_RESET = DB_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIANS_PER_TICK = 1'd0,
    REG_DEADBAND_TICKS = 1'd1
  } cfg_reg_t;

endpackage

@@ rtl/core/wera_if.sv @@
// Interfaces: encoder sample channel and totals channel.
interface wera_in_if;
  logic valid;
  logic ready;
  logic [wera_pkg::COUNT_W-1:0] left_count;
  logic [wera_pkg::COUNT_W-1:0] right_count;

  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface wera_out_if;
  logic valid;
  logic ready;
  logic updated;
  logic signed [wera_pkg::TOTAL_W-1:0] left_total;
  logic signed [wera_pkg::TOTAL_W-1:0] right_total;

  modport source (output valid, updated, left_total, right_total, input ready);
  modport sink (input valid, updated, left_total, right_total, output ready);
endinterface

@@ rtl/core/wheel_encoder_rollover_accumulator.sv @@
// Top level: wheel encoder delta with rollover, scaling and saturating totals.
//
//  channel  | dir | word                                  | handshake
//  ---------+-----+---------------------------------------+------------------
//  in_ch    | in  | left_count, right_count (15b each)    | valid / ready
//  out_ch   | out | updated, left_total, right_total (40b)| valid / ready
//  cfg      | in  | cfg_index selects register, cfg_data  | cfg_we, no wait
//
// One word per clock while out_ch takes results; stages: input register, delta and deadband
// (updates the stored positions), multiply, saturating accumulate into the
// output register. Each stage moves on when it is empty or its successor
// moves, so words are taken into bubbles while a result waits on out_ch.
// Synchronous reset clears valids, stored positions, seed flag and totals.
module wheel_encoder_rollover_accumulator (
  input  logic clk,
  input  logic rst,
  wera_in_if.sink in_ch,
  wera_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [wera_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wera_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = wera_pkg::COUNT_W;
  localparam int DW = wera_pkg::DELTA_W;
  localparam int PW = wera_pkg::PROD_W;
  localparam int TW = wera_pkg::TOTAL_W;

  localparam logic signed [DW-1:0] MOD_D = DW'(wera_pkg::COUNT_MODULUS);
  localparam logic signed [DW-1:0] HALF_D = DW'(wera_pkg::COUNT_HALF);

  // configuration
  logic [wera_pkg::RPT_W-1:0] radians_per_tick;
  logic [wera_pkg::DB_W-1:0] deadband_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      radians_per_tick <= wera_pkg::RPT_RESET;
      deadband_ticks <= wera_pkg::DB_RESET;
    end else if (cfg_we) begin
      unique case (wera_pkg::cfg_reg_t'(cfg_index))
        wera_pkg::REG_RADIANS_PER_TICK: radians_per_tick <= cfg_data;
        wera_pkg::REG_DEADBAND_TICKS: deadband_ticks <= cfg_data[wera_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and stage readies
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !v3 || out_ch.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign in_ch.ready = rdy0;

  // stage 0: input register
  logic [CW-1:0] s0_left, s0_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_ch.valid) begin
      s0_left <= in_ch.left_count;
      s0_right <= in_ch.right_count;
    end
  end

  // stage 1: seed, deadband and rollover delta
  logic [CW-1:0] last_left, last_right;
  logic seeded;
  logic seed_now;
  logic [CW-1:0] old_left, old_right;
  logic signed [DW-1:0] diff_left, diff_right;
  logic signed [DW-1:0] mag_left, mag_right;
  logic signed [DW-1:0] delta_left, delta_right;
  logic upd;

  logic signed [DW-1:0] s1_dl, s1_drn;
  logic s1_upd;

  always_comb begin
    seed_now = !seeded && (s0_left != '0) && (s0_right != '0);
    old_left = seed_now ? s0_left : last_left;
    old_right = seed_now ? s0_right : last_right;
    diff_left = $signed({2'b00, s0_left}) - $signed({2'b00, old_left});
    diff_right = $signed({2'b00, s0_right}) - $signed({2'b00, old_right});
    mag_left = diff_left[DW-1] ? -diff_left : diff_left;
    mag_right = diff_right[DW-1] ? -diff_right : diff_right;
    upd = (mag_left > $signed({3'b000, deadband_ticks}))
       || (mag_right > $signed({3'b000, deadband_ticks}));
    // below half a turn: plain difference, else wrap toward the short way
    if (mag_left < HALF_D) begin
      delta_left = diff_left;
    end else if (diff_left[DW-1]) begin
      delta_left = diff_left + MOD_D;
    end else begin
      delta_left = diff_left - MOD_D;
    end
    if (mag_right < HALF_D) begin
      delta_right = diff_right;
    end else if (diff_right[DW-1]) begin
      delta_right = diff_right + MOD_D;
    end else begin
      delta_right = diff_right - MOD_D;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      seeded <= 1'b0;
      last_left <= '0;
      last_right <= '0;
    end else if (rdy1) begin
      v1 <= v0;
      if (v0) begin
        if (seed_now) begin
          seeded <= 1'b1;
        end
        if (upd || seed_now) begin
          last_left <= s0_left;
          last_right <= s0_right;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      s1_upd <= upd;
      s1_dl <= upd ? delta_left : '0;
      s1_drn <= upd ? -delta_right : '0;
    end
  end

  // stage 2: scale by radians per tick
  logic signed [PW-1:0] s2_pl, s2_pr;
  logic s2_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_upd <= s1_upd;
      s2_pl <= PW'(s1_dl * $signed({1'b0, radians_per_tick}));
      s2_pr <= PW'(s1_drn * $signed({1'b0, radians_per_tick}));
    end
  end

  // stage 3: saturating accumulate, registers double as the output word
  logic signed [TW-1:0] left_sum, right_sum;
  logic updated;
  logic signed [TW:0] left_sum_next, right_sum_next;

  localparam logic signed [TW-1:0] TOT_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] TOT_MIN = {1'b1, {(TW-1){1'b0}}};

  always_comb begin
    left_sum_next = {left_sum[TW-1], left_sum} + (TW+1)'(s2_pl);
    right_sum_next = {right_sum[TW-1], right_sum} + (TW+1)'(s2_pr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      left_sum <= '0;
      right_sum <= '0;
    end else if (rdy3) begin
      v3 <= v2;
      if (v2) begin
        if (left_sum_next[TW] != left_sum_next[TW-1]) begin
          left_sum <= left_sum_next[TW] ? TOT_MIN : TOT_MAX;
        end else begin
          left_sum <= left_sum_next[TW-1:0];
        end
        if (right_sum_next[TW] != right_sum_next[TW-1]) begin
          right_sum <= right_sum_next[TW] ? TOT_MIN : TOT_MAX;
        end else begin
          right_sum <= right_sum_next[TW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      updated <= s2_upd;
    end
  end

  assign out_ch.valid = v3;
  assign out_ch.updated = updated;
  assign out_ch.left_total = left_sum;
  assign out_ch.right_total = right_sum;

endmodule

@@ tb/wheel_encoder_rollover_accumulator_tb.sv @@
// Testbench: wheel encoder rollover accumulator, random stalls with a running totals scoreboard.
`timescale 1ns / 100ps

module wheel_encoder_rollover_accumulator_tb;
  import wera_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 64;
  localparam int DRAIN_WAIT = 8;
  localparam int PHASE_WORDS = 330;

  typedef struct packed {
    logic updated;
    logic [TOTAL_W-1:0] left_total;
    logic [TOTAL_W-1:0] right_total;
  } totals_t;

  class wheel_totals_model;
    logic [RPT_W-1:0] rpt;
    logic [DB_W-1:0] db;
    logic [COUNT_W-1:0] last_l;
    logic [COUNT_W-1:0] last_r;
    bit seeded;
    longint left_sum;
    longint right_sum;
    totals_t expected_totals[$];
    int mismatches;
    int results_seen;

    function new();
      rpt = RPT_RESET;
      db = DB_RESET;
      last_l = '0;
      last_r = '0;
      seeded = 0;
      left_sum = 0;
      right_sum = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_regs(logic [RPT_W-1:0] rpt_v, logic [CFG_DATA_W-1:0] db_word);
      rpt = rpt_v;
      db = db_word[DB_W-1:0];
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // rollover with period COUNT_MODULUS once the plain step reaches half of it
    function longint tick_delta(longint old_pos, longint new_pos);
      longint d;
      d = new_pos - old_pos;
      if (mag(d) < COUNT_HALF) return d;
      if (old_pos > new_pos) return COUNT_MODULUS - old_pos + new_pos;
      return -(COUNT_MODULUS - new_pos + old_pos);
    endfunction

    function longint sat_add(longint acc, longint inc);
      longint s;
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (TOTAL_W - 1)) - 1;
      lo = -(longint'(1) <<< (TOTAL_W - 1));
      s = acc + inc;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s;
    endfunction

    function void note_sample(logic [COUNT_W-1:0] l, logic [COUNT_W-1:0] r);
      longint pl;
      longint pr;
      longint nl;
      longint nr;
      longint dbv;
      longint scale;
      bit move;
      totals_t want;
      if (!seeded && l != 0 && r != 0) begin
        last_l = l;
        last_r = r;
        seeded = 1;
      end
      pl = last_l;
      pr = last_r;
      nl = l;
      nr = r;
      dbv = db;
      scale = rpt;
      move = (mag(pl - nl) > dbv) || (mag(pr - nr) > dbv);
      if (move) begin
        left_sum = sat_add(left_sum, tick_delta(pl, nl) * scale);
        right_sum = sat_add(right_sum, -(tick_delta(pr, nr) * scale));
        last_l = l;
        last_r = r;
      end
      want.updated = move;
      want.left_total = left_sum[TOTAL_W-1:0];
      want.right_total = right_sum[TOTAL_W-1:0];
      expected_totals.push_back(want);
    endfunction

    function void check_totals(logic u, logic [TOTAL_W-1:0] lt, logic [TOTAL_W-1:0] rt);
      totals_t want;
      results_seen++;
      if (expected_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d unexpected: updated %0b left %0d right %0d",
                   results_seen, u, $signed(lt), $signed(rt));
        return;
      end
      want = expected_totals.pop_front();
      if (u !== want.updated || lt !== want.left_total || rt !== want.right_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: updated exp %0b got %0b, left exp %0d got %0d, right exp %0d got %0d",
                   results_seen, want.updated, u, $signed(want.left_total), $signed(lt),
                   $signed(want.right_total), $signed(rt));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [COUNT_W-1:0] cur_l;
  logic [COUNT_W-1:0] cur_r;
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;
  int quiet_cycles;

  wheel_totals_model model = new();

  wera_in_if in_ch();
  wera_out_if out_ch();

  wheel_encoder_rollover_accumulator dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        model.check_totals(out_ch.updated, out_ch.left_total, out_ch.right_total);
      if (in_ch.valid && in_ch.ready)
        model.note_sample(in_ch.left_count, in_ch.right_count);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random short stalls, plus one long hold on request
  initial begin
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_ch.ready <= 1'b0;
        burst_left--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        burst_left = $urandom_range(1, 4) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic drive_sample(input logic [COUNT_W-1:0] l, input logic [COUNT_W-1:0] r);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_count <= l;
    in_ch.right_count <= r;
    do @(posedge clk); while (!in_ch.ready);
    cur_l = l;
    cur_r = r;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // bits above the deadband width ride along in the data word and must be ignored
  task automatic write_config(input logic [RPT_W-1:0] rpt_v, input logic [DB_W-1:0] db_v);
    logic [CFG_DATA_W-1:0] db_word;
    db_word = {6'($urandom), db_v};
    cfg_we <= 1'b1;
    cfg_index <= REG_RADIANS_PER_TICK;
    cfg_data <= rpt_v;
    @(negedge clk);
    cfg_index <= REG_DEADBAND_TICKS;
    cfg_data <= db_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.set_regs(rpt_v, db_word);
  endtask

  function automatic int pick_step(int db, int bias);
    int k;
    int m;
    int sgn;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: m = $urandom_range(0, db);
      2: m = db + $urandom_range(0, 1);
      3, 4, 5: m = $urandom_range(0, 300);
      6: m = $urandom_range(COUNT_HALF - 3, COUNT_HALF + 3);
      7: m = $urandom_range(0, 32767);
      default: m = $urandom_range(1000, COUNT_HALF - 1);
    endcase
    if (bias != 0 && k >= 3) sgn = bias;
    else sgn = $urandom_range(0, 1) ? 1 : -1;
    return m * sgn;
  endfunction

  task automatic run_phase(input int n, input int bias);
    int k;
    logic [COUNT_W-1:0] l;
    logic [COUNT_W-1:0] r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 16) begin
        l = COUNT_W'(int'(cur_l) + pick_step(int'(model.db), bias));
        r = COUNT_W'(int'(cur_r) + pick_step(int'(model.db), bias));
      end else if (k < 19) begin
        l = COUNT_W'($urandom);
        r = COUNT_W'($urandom);
      end else begin
        l = cur_l;
        r = cur_r;
      end
      drive_sample(l, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_RADIANS_PER_TICK;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    cur_l = '0;
    cur_r = '0;
    src_idle_en = 1;
    sink_idle_en = 1;
    hold_req = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // unseeded: deadband and update run against the stored positions, which start at zero
    drive_sample(15'd0, 15'd0);
    drive_sample(15'd0, 15'd5);
    drive_sample(15'd0, 15'd6);
    drive_sample(15'd32767, 15'd0);
    // seeding word, then deadband edge
    drive_sample(15'd100, 15'd200);
    drive_sample(15'd105, 15'd200);
    drive_sample(15'd106, 15'd195);
    // half-period boundary and rollover both ways
    drive_sample(15'd16488, 15'd195);
    drive_sample(15'd105, 15'd195);
    drive_sample(15'd32767, 15'd0);
    drive_sample(15'd0, 15'd32767);
    drive_sample(15'd32767, 15'd32767);
    drive_sample(15'd0, 15'd0);
    drive_sample(15'd16383, 15'd16384);
    drive_sample(15'd0, 15'd16383);
    drive_sample(15'd16383, 15'd0);
    drive_sample(15'd21845, 15'd10922);
    drive_sample(15'd10922, 15'd21845);

    drain();
    write_config({RPT_W{1'b1}}, '0);
    run_phase(PHASE_WORDS, 1);

    drain();
    write_config({RPT_W{1'b1}}, DB_W'(2));
    hold_req = 1;
    run_phase(PHASE_WORDS, -1);

    drain();
    write_config('0, {DB_W{1'b1}});
    run_phase(PHASE_WORDS, 0);

    drain();
    write_config(RPT_W'(1), DB_W'(1));
    run_phase(PHASE_WORDS, 0);

    drain();
    write_config(RPT_W'($urandom), DB_W'($urandom_range(0, 400)));
    run_phase(PHASE_WORDS, 1);

    drain();
    src_idle_en = 0;
    sink_idle_en = 0;
    write_config(RPT_RESET, DB_RESET);
    run_phase(PHASE_WORDS, 0);

    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/wera_pkg.sv
rtl/core/wera_if.sv
rtl/core/wheel_encoder_rollover_accumulator.sv
tb/wheel_encoder_rollover_accumulator_tb.sv
